// ===== src/line_follower_steering_core_assert.svh =====
// Assertion macros shared by the steering core RTL.
// Set NO_ASSERTIONS to build without them.
`ifndef LINE_FOLLOWER_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOWER_STEERING_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define LFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define LFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/lfs_pkg.sv =====
package lfs_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MIDDLE_WEIGHT = 3'd0;
  localparam logic [2:0] CFG_SIDE_WEIGHT   = 3'd1;
  localparam logic [2:0] CFG_TRIM          = 3'd2;
  localparam logic [2:0] CFG_SEARCH_SPEED  = 3'd3;
  localparam logic [2:0] CFG_START_HEADING = 3'd4;

  localparam int unsigned CFG_DATA_W = 8;

  // Register reset values
  localparam logic [6:0] RST_MIDDLE_WEIGHT = 7'd60;
  localparam logic [6:0] RST_SIDE_WEIGHT   = 7'd90;
  localparam logic [4:0] RST_TRIM          = 5'd10;
  localparam logic [7:0] RST_SEARCH_SPEED  = 8'd80;

  // Heading codes
  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_DOWN  = 2'd1;
  localparam logic [1:0] HEAD_LEFT  = 2'd2;
  localparam logic [1:0] HEAD_RIGHT = 2'd3;

  // Two-bit step patterns
  localparam logic [1:0] STEP_POS = 2'b01;
  localparam logic [1:0] STEP_NEG = 2'b11;

  // Axis select in the turn table
  localparam logic AXIS_A = 1'b0;
  localparam logic AXIS_B = 1'b1;

  typedef enum logic [1:0] {
    PAUSE_NONE    = 2'd0,
    PAUSE_SHORT   = 2'd1,
    PAUSE_CROSS   = 2'd2,
    PAUSE_REVERSE = 2'd3
  } pause_e;

  typedef enum logic [1:0] {
    KIND_LEFT_HOT  = 2'd0,
    KIND_RIGHT_HOT = 2'd1,
    KIND_STRAIGHT  = 2'd2,
    KIND_REVERSE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic       axis;
    logic [1:0] want;
    logic [1:0] new_heading;
    kind_e      kind;
  } choice_t;

  // Turn choices per heading, tried in order; first match wins
  localparam choice_t CHOICES [4][4] = '{
    '{ '{AXIS_A, STEP_POS, HEAD_RIGHT, KIND_LEFT_HOT},
       '{AXIS_A, STEP_NEG, HEAD_LEFT,  KIND_RIGHT_HOT},
       '{AXIS_B, STEP_POS, HEAD_UP,    KIND_STRAIGHT},
       '{AXIS_B, STEP_NEG, HEAD_DOWN,  KIND_REVERSE} },
    '{ '{AXIS_A, STEP_POS, HEAD_RIGHT, KIND_RIGHT_HOT},
       '{AXIS_A, STEP_NEG, HEAD_LEFT,  KIND_LEFT_HOT},
       '{AXIS_B, STEP_NEG, HEAD_DOWN,  KIND_STRAIGHT},
       '{AXIS_B, STEP_POS, HEAD_UP,    KIND_REVERSE} },
    '{ '{AXIS_A, STEP_NEG, HEAD_LEFT,  KIND_STRAIGHT},
       '{AXIS_B, STEP_POS, HEAD_UP,    KIND_LEFT_HOT},
       '{AXIS_B, STEP_NEG, HEAD_DOWN,  KIND_RIGHT_HOT},
       '{AXIS_A, STEP_POS, HEAD_RIGHT, KIND_REVERSE} },
    '{ '{AXIS_B, STEP_POS, HEAD_UP,    KIND_RIGHT_HOT},
       '{AXIS_A, STEP_POS, HEAD_RIGHT, KIND_STRAIGHT},
       '{AXIS_B, STEP_NEG, HEAD_DOWN,  KIND_LEFT_HOT},
       '{AXIS_A, STEP_NEG, HEAD_LEFT,  KIND_REVERSE} }
  };

  // Captured sample
  typedef struct packed {
    logic [3:0]        sensor_bits;
    logic signed [1:0] next_step_a;
    logic signed [1:0] next_step_b;
  } sample_t;

  // Wheel command result
  typedef struct packed {
    logic       drive_valid;
    logic       left_forward;
    logic [7:0] left_wheel_spd;
    logic       right_forward;
    logic [7:0] right_wheel_spd;
    logic [1:0] heading_now;
    logic       at_crossing;
    pause_e     pause_code;
  } result_t;

  // Clamp a nine-bit speed to eight bits
  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

endpackage

// ===== src/lfs_in_if.sv =====
interface lfs_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        sensor_bits;
  logic signed [1:0] next_step_a;
  logic signed [1:0] next_step_b;

  modport source (output valid, output sensor_bits, output next_step_a,
                  output next_step_b, input ready);
  modport sink   (input valid, input sensor_bits, input next_step_a,
                  input next_step_b, output ready);
endinterface

// ===== src/lfs_out_if.sv =====
interface lfs_out_if;
  logic       valid;
  logic       ready;
  logic       drive_valid;
  logic       left_forward;
  logic [7:0] left_wheel_spd;
  logic       right_forward;
  logic [7:0] right_wheel_spd;
  logic [1:0] heading_now;
  logic       at_crossing;
  logic [1:0] pause_code;

  modport source (output valid, output drive_valid, output left_forward,
                  output left_wheel_spd, output right_forward, output right_wheel_spd,
                  output heading_now, output at_crossing, output pause_code,
                  input ready);
  modport sink   (input valid, input drive_valid, input left_forward,
                  input left_wheel_spd, input right_forward, input right_wheel_spd,
                  input heading_now, input at_crossing, input pause_code,
                  output ready);
endinterface

// ===== src/line_follower_steering_core.sv =====
// Channel    | Role   | Carries
// -----------+--------+----------------------------------------------------
// sample_i   | sink   | sensor_bits, next_step_a, next_step_b
// drive_o    | source | drive_valid, left/right direction and speed,
//            |        | heading_now, at_crossing, pause_code
// cfg_*_i    | write  | index 0..4: middle_weight, side_weight, trim,
//            |        | search_speed, start_heading
//
// One transaction per cycle sustained unless drive_o stalls. A sample
// accepted into the input register moves on to the result register, where
// it is offered on drive_o; the heading is read and updated on that move.
// Reset (rst_ni low, asynchronous) empties both registers, loads register
// defaults and sets heading to up. A stalled drive_o holds its result; the
// input register still takes one more sample behind it.
`include "line_follower_steering_core_assert.svh"

module line_follower_steering_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lfs_in_if.sink                       sample_i,
  lfs_out_if.source                    drive_o
);

  // Configuration registers
  logic [6:0] middle_weight_q;
  logic [6:0] side_weight_q;
  logic [4:0] trim_q;
  logic [7:0] search_speed_q;
  logic [1:0] heading_q, heading_d;

  // Pipeline registers
  logic             in_valid_q;
  lfs_pkg::sample_t in_q;
  logic             out_valid_q;
  lfs_pkg::result_t res_q, res_d;

  logic advance;
  logic take_in;
  logic load_heading;

  // Move a sample on when the result register is empty or being emptied
  assign advance      = in_valid_q && (!out_valid_q || drive_o.ready);
  assign sample_i.ready = !in_valid_q || advance;
  assign take_in      = sample_i.valid && sample_i.ready;
  assign load_heading = cfg_we_i && (cfg_idx_i == lfs_pkg::CFG_START_HEADING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      middle_weight_q <= lfs_pkg::RST_MIDDLE_WEIGHT;
      side_weight_q   <= lfs_pkg::RST_SIDE_WEIGHT;
      trim_q          <= lfs_pkg::RST_TRIM;
      search_speed_q  <= lfs_pkg::RST_SEARCH_SPEED;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfs_pkg::CFG_MIDDLE_WEIGHT: middle_weight_q <= cfg_data_i[6:0];
        lfs_pkg::CFG_SIDE_WEIGHT:   side_weight_q   <= cfg_data_i[6:0];
        lfs_pkg::CFG_TRIM:          trim_q          <= cfg_data_i[4:0];
        lfs_pkg::CFG_SEARCH_SPEED:  search_speed_q  <= cfg_data_i;
        default: ; // start heading is loaded into heading_q; others dropped
      endcase
    end
  end

  // Heading: a start_heading write loads it, an advancing sample updates it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= lfs_pkg::HEAD_UP;
    end else if (load_heading) begin
      heading_q <= cfg_data_i[1:0];
    end else if (advance) begin
      heading_q <= heading_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) in_valid_q <= sample_i.valid;
      if (!out_valid_q || drive_o.ready) out_valid_q <= in_valid_q;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q.sensor_bits <= sample_i.sensor_bits;
      in_q.next_step_a <= sample_i.next_step_a;
      in_q.next_step_b <= sample_i.next_step_b;
    end
    if (advance) res_q <= res_d;
  end

  // Steering decision for the sample in the input register
  always_comb begin
    logic [7:0]       rsum, lsum, full;
    logic [7:0]       rkeep, lkeep;
    logic             crossing;
    logic             found;
    logic [1:0]       step;
    lfs_pkg::choice_t ch;

    full = {1'b0, side_weight_q} + {1'b0, middle_weight_q};
    rsum = (in_q.sensor_bits[0] ? 8'd0 : {1'b0, side_weight_q})
         + (in_q.sensor_bits[1] ? 8'd0 : {1'b0, middle_weight_q});
    lsum = (in_q.sensor_bits[2] ? 8'd0 : {1'b0, middle_weight_q})
         + (in_q.sensor_bits[3] ? 8'd0 : {1'b0, side_weight_q});
    crossing = (rsum == full) || (lsum == full);

    res_d.drive_valid     = 1'b1;
    res_d.left_forward    = 1'b1;
    res_d.left_wheel_spd  = 8'd0;
    res_d.right_forward   = 1'b1;
    res_d.right_wheel_spd = 8'd0;
    res_d.at_crossing     = crossing;
    res_d.pause_code      = lfs_pkg::PAUSE_NONE;
    heading_d             = heading_q;
    found                 = 1'b0;
    step                  = 2'b00;
    ch                    = '0;

    // Suppress the weaker side; equal sums keep both
    rkeep = (rsum < lsum) ? 8'd0 : rsum;
    lkeep = (lsum < rkeep) ? 8'd0 : lsum;

    if (crossing) begin
      res_d.pause_code  = lfs_pkg::PAUSE_CROSS;
      res_d.drive_valid = 1'b0;
      // Try the four choices of this heading in order
      for (int k = 0; k < 4; k++) begin
        ch   = lfs_pkg::CHOICES[heading_q][k[1:0]];
        step = (ch.axis == lfs_pkg::AXIS_B) ? $unsigned(in_q.next_step_b)
                                            : $unsigned(in_q.next_step_a);
        if (!found && (step == ch.want)) begin
          found             = 1'b1;
          res_d.drive_valid = 1'b1;
          heading_d         = ch.new_heading;
          case (ch.kind)
            lfs_pkg::KIND_LEFT_HOT: begin
              res_d.left_wheel_spd = full;
            end
            lfs_pkg::KIND_RIGHT_HOT: begin
              res_d.right_wheel_spd = full;
            end
            lfs_pkg::KIND_STRAIGHT: begin
              res_d.left_wheel_spd  = {1'b0, middle_weight_q};
              res_d.right_wheel_spd = {1'b0, middle_weight_q};
            end
            default: begin
              res_d.left_forward    = 1'b0;
              res_d.left_wheel_spd  = lfs_pkg::sat8({1'b0, full} + {4'd0, trim_q});
              res_d.right_wheel_spd = full;
              res_d.pause_code      = lfs_pkg::PAUSE_REVERSE;
            end
          endcase
        end
      end
    end else if ((rsum == 8'd0) && (lsum == 8'd0)) begin
      // Line lost: search ahead
      res_d.left_wheel_spd  = search_speed_q;
      res_d.right_wheel_spd = search_speed_q;
    end else begin
      res_d.left_wheel_spd  = lfs_pkg::sat8({1'b0, lkeep} + {4'd0, trim_q});
      res_d.right_wheel_spd = lfs_pkg::sat8({1'b0, rkeep} + {4'd0, trim_q});
      if ((rkeep == {1'b0, side_weight_q}) || (lkeep == {1'b0, side_weight_q}))
        res_d.pause_code = lfs_pkg::PAUSE_SHORT;
    end

    res_d.heading_now = heading_d;
  end

  assign drive_o.valid           = out_valid_q;
  assign drive_o.drive_valid     = res_q.drive_valid;
  assign drive_o.left_forward    = res_q.left_forward;
  assign drive_o.left_wheel_spd  = res_q.left_wheel_spd;
  assign drive_o.right_forward   = res_q.right_forward;
  assign drive_o.right_wheel_spd = res_q.right_wheel_spd;
  assign drive_o.heading_now     = res_q.heading_now;
  assign drive_o.at_crossing     = res_q.at_crossing;
  assign drive_o.pause_code      = res_q.pause_code;

  // Only a crossing with no matching step may withhold the command
  `LFS_ASSERT_NOW(a_cmd_outside_crossing, clk_i, rst_ni,
                  out_valid_q && !res_q.at_crossing, res_q.drive_valid,
                  "wheel command withheld outside a crossing")

  // Reverse pause comes only with a reversed left wheel at a crossing
  `LFS_ASSERT_NOW(a_reverse_pause, clk_i, rst_ni,
                  out_valid_q && (res_q.pause_code == lfs_pkg::PAUSE_REVERSE),
                  !res_q.left_forward && res_q.at_crossing,
                  "reverse pause without reverse turn")

  // Heading moves only with an advancing sample or a start heading write
  `LFS_ASSERT_NEXT(a_heading_hold, clk_i, rst_ni,
                   !advance && !load_heading, $stable(heading_q),
                   "heading changed without a transaction")

  // Reported heading is the one kept for the next sample
  `LFS_ASSERT_NEXT(a_heading_report, clk_i, rst_ni,
                   advance && !load_heading, res_q.heading_now == heading_q,
                   "reported heading differs from kept heading")

endmodule
